@@ rtl/apq_pkg.sv @@
// shared types and codes for the ascending priority queue
package apq_pkg;

    // operation codes carried on cmd
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } apq_status_t;

    localparam int KEY_W = 32;
    localparam int OCC_W = 5;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // apply the captured item and load the result register
    } apq_ctrl_t;

endpackage

@@ rtl/apq_datapath.sv @@
// sorted key row, parallel compare and shift, item and result registers
module apq_datapath
    import apq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  apq_ctrl_t               ctrl,
    input  logic                    cmd,
    input  logic signed [KEY_W-1:0] key,
    output logic signed [KEY_W-1:0] min_value,
    output logic [1:0]              status,
    output logic [OCC_W-1:0]        occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                    cmd_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic signed [KEY_W-1:0] slot_reg [DEPTH];
    logic signed [KEY_W-1:0] slot_next [DEPTH];
    logic signed [KEY_W-1:0] min_value_reg;
    logic signed [KEY_W-1:0] min_value_next;
    logic [1:0]              status_reg;
    logic [1:0]              status_next;
    logic [OCC_W-1:0]        occupancy_reg;
    logic [CNT_W+OCC_W-1:0]  occ_wide;
    logic [DEPTH-1:0]        le;
    logic                    full;
    logic                    empty;
    logic                    do_insert;
    logic                    do_remove;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_insert = (cmd_reg == CMD_INSERT) && !full;
    assign do_remove = (cmd_reg == CMD_REMOVE) && !empty;

    // per slot: stored key is valid and not greater than the new key
    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        assign le[i] = (CNT_W'(i) < count_reg) && (slot_reg[i] <= key_reg);

        if (i == 0) begin : g_head
            assign slot_next[i] = do_remove ? slot_reg[(DEPTH > 1) ? 1 : 0] :
                                  (le[i] ? slot_reg[i] : key_reg);
        end else if (i == DEPTH - 1) begin : g_tail
            assign slot_next[i] = do_remove ? slot_reg[i] :
                                  (le[i] ? slot_reg[i] :
                                  (le[i-1] ? key_reg : slot_reg[i-1]));
        end else begin : g_mid
            assign slot_next[i] = do_remove ? slot_reg[i+1] :
                                  (le[i] ? slot_reg[i] :
                                  (le[i-1] ? key_reg : slot_reg[i-1]));
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        min_value_next = '0;
        status_next    = ST_OK;
        if (cmd_reg == CMD_INSERT)
        begin
            if (full)
                status_next = ST_FULL;
            else
                count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            if (empty)
                status_next = ST_EMPTY;
            else
            begin
                min_value_next = slot_reg[0];
                count_next     = count_reg - CNT_W'(1);
            end
        end
    end

    assign occ_wide = {{OCC_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.exec)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
            key_reg <= key;
        end
        if (ctrl.exec)
        begin
            min_value_reg <= min_value_next;
            status_reg    <= status_next;
            occupancy_reg <= occ_wide[OCC_W-1:0];
            if (do_insert || do_remove)
                slot_reg <= slot_next;
        end
    end

    assign min_value = min_value_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

endmodule

@@ rtl/apq_controller.sv @@
// handshake control for the ascending priority queue
module apq_controller
    import apq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output apq_ctrl_t ctrl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } apq_state_t;

    apq_state_t state_reg;
    apq_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    // accept only when idle and the output register is empty or draining this cycle
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign ctrl.load = accept;
    assign ctrl.exec = (state_reg == S_EXEC);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item not executed next cycle");

    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> !out_valid_reg)
        else $error("result register still full during execute");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("execute did not present a result");
`endif

endmodule

@@ rtl/ascending_priority_queue_unit.sv @@
// top level of the ascending priority queue unit
// ascending priority queue of signed 32-bit keys held in a sorted row of
// DEPTH registers. cmd 0 inserts key after every stored key less than or
// equal to it (equal keys leave in arrival order); cmd 1 removes and returns
// the smallest key. every item gives one result: min_value (removed key, or
// zero), status (ok, full on a rejected insert, empty on a remove from an
// empty queue) and occupancy (count after the operation, low 5 bits).
// an item is first captured; then, in the execute state, every slot
// compares against the key in parallel and the row shifts up or down in a
// single step, loading the result register. no new item is taken while one
// executes or while a held result is stalled; the result register lets the
// next item be accepted in the same cycle its predecessor's result is taken.
// slot contents need no reset; only the count and control are cleared.
module ascending_priority_queue_unit
    import apq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input item channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    cmd,
    input  logic signed [KEY_W-1:0] key,
    // result item channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [KEY_W-1:0] min_value,
    output logic [1:0]              status,
    output logic [OCC_W-1:0]        occupancy
);

    // capture and execute commands
    apq_ctrl_t ctrl;

    // handshakes and sequencing
    apq_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    // sorted key row with parallel compare, count and result register
    apq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cmd       (cmd),
        .key       (key),
        .min_value (min_value),
        .status    (status),
        .occupancy (occupancy)
    );

endmodule
